// ===== rtl/core/rsfp_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rsfp_pkg - shared types and constants of the radio serial frame parser
// Byte codes, frame layout indexes, the parser state type and the record
// that the front end hands to the back end.
// -----------------------------------------------------------------------------
package rsfp_pkg;

   localparam int DEF_CAPTURE_DEPTH = 16;
   localparam int QUEUE_DEPTH       = 2;    // power of two
   localparam int BYTE_W            = 8;
   localparam int INDEX_W           = 4;
   localparam int FREQ_W            = 18;
   localparam int NAME_W            = 64;
   localparam int NAME_BYTES        = 8;
   localparam int RSP_TDATA_W       = 104;

   // Link bytes
   localparam logic [BYTE_W-1:0] BYTE_START = 8'h02;
   localparam logic [BYTE_W-1:0] CMD_LOW_BAT     = 8'h42; // 'B'
   localparam logic [BYTE_W-1:0] CMD_BAT_REL     = 8'h44; // 'D'
   localparam logic [BYTE_W-1:0] CMD_RX          = 8'h4A; // 'J'
   localparam logic [BYTE_W-1:0] CMD_RX_REL      = 8'h56; // 'V'
   localparam logic [BYTE_W-1:0] CMD_DUAL_ON     = 8'h4F; // 'O'
   localparam logic [BYTE_W-1:0] CMD_DUAL_OFF    = 8'h6F; // 'o'
   localparam logic [BYTE_W-1:0] CMD_FRAME_U     = 8'h55; // 'U'
   localparam logic [BYTE_W-1:0] CMD_FRAME_R     = 8'h52; // 'R'

   // Frame layout, as capture store indexes
   localparam logic [INDEX_W-1:0] IDX_FIRST = 4'd1;
   localparam logic [INDEX_W-1:0] IDX_MHZ   = 4'd1;
   localparam logic [INDEX_W-1:0] IDX_STEP  = 4'd2;
   localparam logic [INDEX_W-1:0] IDX_NAME  = 4'd3;
   localparam logic [INDEX_W-1:0] IDX_MEM   = 4'd11;
   localparam logic [INDEX_W-1:0] LAST_U    = 4'd11;
   localparam logic [INDEX_W-1:0] LAST_R    = 4'd12;

   localparam logic [FREQ_W-1:0] KHZ_PER_MHZ  = 18'd1000;
   localparam logic [FREQ_W-1:0] KHZ_PER_STEP = 18'd5;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_CMD   = 2'd1,
      PH_FRAME = 2'd2
   } phase_type;

   typedef enum logic {
      KIND_U = 1'b0,
      KIND_R = 1'b1
   } kind_type;

   // One decoded command, handed from the front end to the back end.
   typedef struct packed {
      logic [BYTE_W-1:0] cmd;
      logic [BYTE_W-1:0] mhz;
      logic [BYTE_W-1:0] step;
      logic [NAME_W-1:0] name;
      logic [BYTE_W-1:0] slot;
      logic              ok;
   } job_type;

   // Handshake between front end and queue.
   typedef struct packed {
      logic push;
      logic full;
   } qctl_type;

   function automatic logic is_status_cmd(input logic [BYTE_W-1:0] b);
      return (b == CMD_LOW_BAT) || (b == CMD_BAT_REL) || (b == CMD_RX) ||
             (b == CMD_RX_REL) || (b == CMD_DUAL_ON) || (b == CMD_DUAL_OFF);
   endfunction

endpackage

// ===== rtl/core/radio_serial_frame_parser.sv =====
`timescale 1ns / 1ps
// Path: the record of a completed command is written into the command queue
// and from there into the registered result word that the sink takes.
// Throughput: one byte per cycle; the parser state machine takes a byte in
// every cycle unless the two-entry command queue is full.
// Reset: synchronous, active high; the parser returns to idle, the queue and
// the result register empty. The capture store is not cleared.
// -----------------------------------------------------------------------------
// radio_serial_frame_parser - top level
// Parses the byte stream of a radio's serial link into status commands and
// frequency/name frames, one result word per completed command.
// -----------------------------------------------------------------------------
module radio_serial_frame_parser #(
   parameter int CAPTURE_DEPTH = rsfp_pkg::DEF_CAPTURE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   // Received bytes.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rsfp_pkg::BYTE_W-1:0]      req_tdata,   // [7:0] rx_byte
   // Decoded commands.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] cmd_code, [25:8] freq_khz, [89:26] station_name,
   // [97:90] memory_slot, [98] checksum_ok, [103:99] zero
   output logic [rsfp_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import rsfp_pkg::*;

   // The front end owns the link state machine. Idle bytes other than the
   // start byte are dropped, the byte after the start byte selects either a
   // status command or a U/R frame. Frame bytes land in the capture store
   // and the closing checksum byte is compared against MHz xor step.
   qctl_type qctl;
   job_type  push_job;
   job_type  pop_job;
   logic     q_full;
   logic     q_valid;
   logic     pop;

   rsfp_front #(
      .CAPTURE_DEPTH(CAPTURE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .qctl_out   (qctl),
      .q_full     (q_full),
      .job        (push_job)
   );

   // The queue lets the parser keep taking bytes while the sink holds off.
   rsfp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .qctl_in  (qctl),
      .push_job (push_job),
      .full     (q_full),
      .q_valid  (q_valid),
      .pop      (pop),
      .pop_job  (pop_job)
   );

   // The back end does the kHz conversion (two constant multiplies and an
   // add) into the registered result word.
   rsfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .pop_job    (pop_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/core/rsfp_front.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rsfp_front - byte parser front end
// Tracks the link state, captures frame bytes and pushes one decoded
// command record into the queue when a command or frame completes.
// -----------------------------------------------------------------------------
module rsfp_front #(
   parameter int CAPTURE_DEPTH = rsfp_pkg::DEF_CAPTURE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [rsfp_pkg::BYTE_W-1:0] req_tdata,
   output rsfp_pkg::qctl_type       qctl_out,
   input  logic                     q_full,
   output rsfp_pkg::job_type        job
);
   import rsfp_pkg::*;

   localparam int STORE_AW = $clog2(CAPTURE_DEPTH);
   localparam logic [INDEX_W:0] DEPTH_LIM = (INDEX_W+1)'(CAPTURE_DEPTH);

   phase_type         phase_ff, phase_in;
   kind_type          kind_ff, kind_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [BYTE_W-1:0] store_ff [CAPTURE_DEPTH];

   logic              accept;
   logic              frame_done;
   logic [INDEX_W-1:0] last_index;
   logic [BYTE_W-1:0] b;
   logic [NAME_W-1:0] name_cat;

   assign b          = req_tdata;
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign last_index = (kind_ff == KIND_R) ? LAST_R : LAST_U;
   assign frame_done = (index_ff >= last_index);

   always_comb begin
      name_cat = '0;
      for (int i = 0; i < NAME_BYTES; i++) begin
         name_cat[NAME_W-1-BYTE_W*i -: BYTE_W] =
            store_ff[STORE_AW'(IDX_NAME) + STORE_AW'(i)];
      end
   end

   // Next state
   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      index_in = index_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_CMD: begin
               if ((b == CMD_FRAME_U) || (b == CMD_FRAME_R)) begin
                  phase_in = PH_FRAME;
                  kind_in  = (b == CMD_FRAME_R) ? KIND_R : KIND_U;
                  index_in = IDX_FIRST;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_FRAME: begin
               if (frame_done) begin
                  phase_in = PH_IDLE;
                  index_in = IDX_FIRST;
               end else begin
                  index_in = index_ff + INDEX_W'(1);
               end
            end
            default: begin
               phase_in = (b == BYTE_START) ? PH_CMD : PH_IDLE;
            end
         endcase
      end
   end

   // Outputs
   always_comb begin
      qctl_out.push = 1'b0;
      qctl_out.full = q_full;
      job           = '0;
      unique case (phase_ff)
         PH_CMD: begin
            if (accept && is_status_cmd(b)) begin
               qctl_out.push = 1'b1;
               job.cmd       = b;
               job.ok        = 1'b1;
            end
         end
         PH_FRAME: begin
            if (accept && frame_done) begin
               qctl_out.push = 1'b1;
               job.cmd  = (kind_ff == KIND_R) ? CMD_FRAME_R : CMD_FRAME_U;
               job.mhz  = store_ff[STORE_AW'(IDX_MHZ)];
               job.step = store_ff[STORE_AW'(IDX_STEP)];
               job.name = name_cat;
               job.slot = (kind_ff == KIND_R) ? store_ff[STORE_AW'(IDX_MEM)] : '0;
               // The checksum is the byte on the link right now.
               job.ok   = (b == (store_ff[STORE_AW'(IDX_MHZ)] ^
                                 store_ff[STORE_AW'(IDX_STEP)]));
            end
         end
         default: begin
            qctl_out.push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         kind_ff  <= KIND_U;
         index_ff <= IDX_FIRST;
      end else begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (phase_ff == PH_FRAME) && ({1'b0, index_ff} < DEPTH_LIM)) begin
         store_ff[index_ff[STORE_AW-1:0]] <= b;
      end
   end

endmodule

// ===== rtl/core/rsfp_queue.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rsfp_queue - command record queue
// Small first-in first-out buffer between the parser and the result stage.
// -----------------------------------------------------------------------------
module rsfp_queue (
   input  logic              clock,
   input  logic              reset,
   input  rsfp_pkg::qctl_type qctl_in,
   input  rsfp_pkg::job_type push_job,
   output logic              full,
   output logic              q_valid,
   input  logic              pop,
   output rsfp_pkg::job_type pop_job
);
   import rsfp_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign q_valid = (count_ff != '0);
   assign do_push = qctl_in.push && !full;
   assign do_pop  = pop && q_valid;
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/core/rsfp_back.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rsfp_back - result stage
// Converts MHz and step to kHz and holds the result word for the sink.
// -----------------------------------------------------------------------------
module rsfp_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  rsfp_pkg::job_type               pop_job,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rsfp_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import rsfp_pkg::*;

   localparam int USED_W = 2*BYTE_W + FREQ_W + NAME_W + 1;

   logic                   valid_ff, valid_in;
   logic [RSP_TDATA_W-1:0] data_ff, data_in;
   logic [FREQ_W-1:0]      freq;

   assign pop  = q_valid && (!valid_ff || rsp_tready);
   assign freq = FREQ_W'(pop_job.mhz) * KHZ_PER_MHZ +
                 FREQ_W'(pop_job.step) * KHZ_PER_STEP;

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
      data_in = {{(RSP_TDATA_W-USED_W){1'b0}}, pop_job.ok, pop_job.slot,
                 pop_job.name, freq, pop_job.cmd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

// ===== rtl/core/rsfp_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rsfp_checker - port level checks of the frame parser
// Watches the result channel for handshake and content rules.
// -----------------------------------------------------------------------------
module rsfp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [rsfp_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import rsfp_pkg::*;

   logic [BYTE_W-1:0] cmd;
   assign cmd = rsp_tdata[7:0];

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_status_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((cmd == CMD_LOW_BAT) || (cmd == CMD_BAT_REL) ||
                     (cmd == CMD_RX) || (cmd == CMD_RX_REL) ||
                     (cmd == CMD_DUAL_ON) || (cmd == CMD_DUAL_OFF))
      |-> (rsp_tdata[97:8] == '0) && rsp_tdata[98])
      else $error("status command carries frame data");

   a_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result word without a completing byte");

endmodule

bind radio_serial_frame_parser rsfp_checker u_rsfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== dv/radio_serial_frame_parser_test.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// radio_serial_frame_parser_test - self-checking bench for the frame parser
// Feeds link bytes through the request stream and checks every decoded result
// word against a cycle-free predictor of the parser. The bench opens with a
// short directed table, which covers ping and noise bytes, every status
// command, unknown commands, and U and R frames at the field extremes. It
// then sends random frames, status commands and broken sequences while both
// sides idle at random.
// -----------------------------------------------------------------------------
module radio_serial_frame_parser_test;
   import rsfp_pkg::*;

   localparam int PERIOD_NS     = 20;
   localparam int RESET_CYCLES  = 8;
   localparam int RANDOM_ITEMS  = 500;
   localparam int SETTLE_CYCLES = 16;
   localparam int LIMIT_CYCLES  = 200_000;
   localparam int DIRECTED_ROWS = 46;
   localparam int STATUS_KINDS  = 6;

   // The ping byte that the radio sends while idle; the parser ignores it.
   localparam logic [BYTE_W-1:0] BYTE_PING = 8'h53;

   // One decoded command, as the predictor sees it.
   typedef struct packed {
      logic [BYTE_W-1:0] cmd;
      logic [FREQ_W-1:0] freq;
      logic [NAME_W-1:0] name;
      logic [BYTE_W-1:0] slot;
      logic              ok;
   } radio_report_type;

   // One row of the directed table. Where typed is set, want is the word that
   // the byte must complete, written out by hand.
   typedef struct packed {
      logic [BYTE_W-1:0] rx;
      logic              typed;
      radio_report_type  want;
   } directed_row_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } ready_mode_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [BYTE_W-1:0]      req_tdata  = '0;     // [7:0] rx_byte
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [7:0] cmd_code, [25:8] freq_khz, [89:26] station_name,
   // [97:90] memory_slot, [98] checksum_ok, [103:99] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Predictor state: a copy of the parser's phase, frame kind, write index
   // and capture store.
   phase_type         link_phase  = PH_IDLE;
   kind_type          link_kind   = KIND_U;
   logic [INDEX_W-1:0] fill_index = IDX_FIRST;
   logic [BYTE_W-1:0] captured [0:DEF_CAPTURE_DEPTH-1];

   radio_report_type awaited_reports [$];

   int errors        = 0;
   int bytes_sent    = 0;
   int counted_items = 0;
   int burst_left    = 0;
   int words_checked = 0;
   int status_words  = 0;
   int u_words       = 0;
   int r_words       = 0;
   int bad_sums      = 0;

   ready_mode_type stall_mode = READY_ALWAYS;
   int             stall_tick = 0;

   radio_serial_frame_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(PERIOD_NS / 2) clock = ~clock;

   // ---------------------------------------------------------------------------
   // Predictor: advances the copied parser state by one byte. Returns 1 when
   // the byte completes a command, with the decoded word in word.
   // ---------------------------------------------------------------------------
   function automatic bit parse_link_byte(input logic [BYTE_W-1:0] b,
                                          output radio_report_type word);
      logic [INDEX_W-1:0] last;
      logic [BYTE_W-1:0]  mhz;
      logic [BYTE_W-1:0]  step;
      int                 i;
      word = '0;
      case (link_phase)
         PH_CMD: begin
            link_phase = PH_IDLE;
            case (b)
               CMD_LOW_BAT, CMD_BAT_REL, CMD_RX, CMD_RX_REL, CMD_DUAL_ON,
               CMD_DUAL_OFF: begin
                  word.cmd = b;
                  word.ok  = 1'b1;
                  return 1'b1;
               end
               CMD_FRAME_U, CMD_FRAME_R: begin
                  link_kind  = (b == CMD_FRAME_R) ? KIND_R : KIND_U;
                  fill_index = IDX_FIRST;
                  link_phase = PH_FRAME;
               end
               default: ;   // unknown command: silently back to idle
            endcase
            return 1'b0;
         end
         PH_FRAME: begin
            last = (link_kind == KIND_R) ? LAST_R : LAST_U;
            captured[fill_index] = b;
            if (fill_index < last) begin
               fill_index = fill_index + INDEX_W'(1);
               return 1'b0;
            end
            mhz  = captured[IDX_MHZ];
            step = captured[IDX_STEP];
            word.cmd  = (link_kind == KIND_R) ? CMD_FRAME_R : CMD_FRAME_U;
            word.freq = FREQ_W'(mhz) * KHZ_PER_MHZ + FREQ_W'(step) * KHZ_PER_STEP;
            for (i = 0; i < NAME_BYTES; i++)
               word.name = {word.name[NAME_W-BYTE_W-1:0], captured[IDX_NAME + i]};
            word.slot = (link_kind == KIND_R) ? captured[IDX_MEM] : '0;
            // A bad checksum still yields a word, only with the flag cleared.
            word.ok   = (captured[last] == (mhz ^ step));
            link_phase = PH_IDLE;
            fill_index = IDX_FIRST;
            return 1'b1;
         end
         default: begin
            // Idle: everything but the start byte is dropped, pings included.
            link_phase = (b == BYTE_START) ? PH_CMD : PH_IDLE;
            return 1'b0;
         end
      endcase
   endfunction

   function automatic radio_report_type status_word(input logic [BYTE_W-1:0] code);
      return {code, {FREQ_W{1'b0}}, {NAME_W{1'b0}}, {BYTE_W{1'b0}}, 1'b1};
   endfunction

   function automatic logic [BYTE_W-1:0] status_code(input int n);
      case (n)
         0:       return CMD_LOW_BAT;
         1:       return CMD_BAT_REL;
         2:       return CMD_RX;
         3:       return CMD_RX_REL;
         4:       return CMD_DUAL_ON;
         default: return CMD_DUAL_OFF;
      endcase
   endfunction

   // Directed table. The U frame runs MHz and step at their maximum, so the
   // frequency is the largest one the link can carry; the R frame runs them at
   // zero with the top memory number and a checksum that does not match.
   function automatic directed_row_type directed_row(input int n);
      directed_row_type r;
      r = '0;
      case (n)
         0:  r.rx = BYTE_PING;                          // ping while idle
         1:  r.rx = 8'hFF;                              // noise while idle
         2, 4, 6, 8, 10, 12, 14, 16, 17, 19, 32:
             r.rx = BYTE_START;
         3:  r = {CMD_LOW_BAT,  1'b1, status_word(CMD_LOW_BAT)};
         5:  r = {CMD_BAT_REL,  1'b1, status_word(CMD_BAT_REL)};
         7:  r = {CMD_RX,       1'b1, status_word(CMD_RX)};
         9:  r = {CMD_RX_REL,   1'b1, status_word(CMD_RX_REL)};
         11: r = {CMD_DUAL_ON,  1'b1, status_word(CMD_DUAL_ON)};
         13: r = {CMD_DUAL_OFF, 1'b1, status_word(CMD_DUAL_OFF)};
         15: r.rx = BYTE_PING;                          // ping as a command
         18: r.rx = CMD_LOW_BAT;                        // dropped, parser idle
         20: r.rx = CMD_FRAME_U;
         21, 22, 23, 24, 25, 26, 27, 28, 29, 30:
             r.rx = 8'hFF;
         31: r = {8'h00, 1'b1,
                  {CMD_FRAME_U, 18'd256275, {NAME_BYTES{8'hFF}}, 8'h00, 1'b1}};
         33: r.rx = CMD_FRAME_R;
         34, 35, 36, 37, 38, 39, 40, 41, 42, 43:
             r.rx = 8'h00;
         44: r.rx = 8'hFF;                              // memory number
         45: r = {8'h01, 1'b1,
                  {CMD_FRAME_R, 18'd0, {NAME_W{1'b0}}, 8'hFF, 1'b0}};
         default: r.rx = 8'h00;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Sender. Bytes go out in bursts of random length with random gaps; now
   // and then a long burst runs with no gap at all.
   // ---------------------------------------------------------------------------
   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
                            input radio_report_type want = '0);
      radio_report_type word;
      bit               done;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
                                                  : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      bytes_sent++;
      done = parse_link_byte(b, word);
      if (typed) word = want;
      if (done || typed) awaited_reports.push_back(word);
   endtask

   // Holds the sender back until every expected word has come out.
   task automatic wait_all_reports();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaited_reports.size() != 0);
      burst_left = $urandom_range(1, 12);
   endtask

   task automatic send_status();
      send_byte(BYTE_START);
      send_byte(status_code($urandom_range(0, STATUS_KINDS - 1)));
      counted_items += 2;
   endtask

   // A complete U or R frame with random content; most checksums are right.
   task automatic send_frame(input kind_type k, input bit good_sum);
      logic [BYTE_W-1:0] mhz;
      logic [BYTE_W-1:0] step;
      logic [BYTE_W-1:0] sum;
      mhz  = 8'($urandom_range(0, 255));
      step = 8'($urandom_range(0, 255));
      sum  = good_sum ? (mhz ^ step) : (mhz ^ step ^ 8'($urandom_range(1, 255)));
      send_byte(BYTE_START);
      send_byte((k == KIND_R) ? CMD_FRAME_R : CMD_FRAME_U);
      send_byte(mhz);
      send_byte(step);
      repeat (NAME_BYTES) send_byte(8'($urandom_range(0, 255)));
      if (k == KIND_R) send_byte(8'($urandom_range(0, 255)));
      send_byte(sum);
      counted_items += (k == KIND_R) ? 14 : 13;
   endtask

   // Noise: a stray byte, a start byte with a random command, or the head of
   // a frame that is cut short, so that the next sequence lands inside it.
   task automatic send_noise();
      int n;
      case ($urandom_range(0, 2))
         0: send_byte(8'($urandom_range(0, 255)));
         1: begin
            send_byte(BYTE_START);
            send_byte(8'($urandom_range(0, 255)));
         end
         default: begin
            send_byte(BYTE_START);
            send_byte($urandom_range(0, 1) ? CMD_FRAME_R : CMD_FRAME_U);
            n = $urandom_range(1, 6);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
         end
      endcase
   endtask

   // ---------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t ns: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
      errors++;
   endtask

   task automatic check_word(input logic [RSP_TDATA_W-1:0] data);
      radio_report_type want;
      if (awaited_reports.size() == 0) begin
         report_mismatch("unexpected result word, cmd_code", 64'(data[7:0]), '0);
         return;
      end
      want = awaited_reports.pop_front();
      words_checked++;
      if (data[98] == 1'b0) bad_sums++;
      if (want.cmd == CMD_FRAME_U)      u_words++;
      else if (want.cmd == CMD_FRAME_R) r_words++;
      else                              status_words++;
      if (data[7:0] !== want.cmd)
         report_mismatch("cmd_code", 64'(data[7:0]), 64'(want.cmd));
      if (data[25:8] !== want.freq)
         report_mismatch("freq_khz", 64'(data[25:8]), 64'(want.freq));
      if (data[89:26] !== want.name)
         report_mismatch("station_name", data[89:26], want.name);
      if (data[97:90] !== want.slot)
         report_mismatch("memory_slot", 64'(data[97:90]), 64'(want.slot));
      if (data[98] !== want.ok)
         report_mismatch("checksum_ok", 64'(data[98]), 64'(want.ok));
      if (data[103:99] !== '0)
         report_mismatch("padding", 64'(data[103:99]), '0);
   endtask

   // Result side: checks each accepted word, then picks the next ready level.
   // The receiver switches between stretches that are always ready, randomly
   // ready, mostly stalled, and ready on a fixed three-in-four beat.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_word(rsp_tdata);
      if (stall_tick == 0) begin
         stall_mode = ready_mode_type'($urandom_range(0, 3));
         stall_tick = $urandom_range(16, 96);
      end else begin
         stall_tick--;
      end
      case (stall_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:      rsp_tready <= (stall_tick % 4) != 0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   initial begin
      directed_row_type row;
      int               n;
      int               pick;
      bit               mid_drained;
      mid_drained = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < DIRECTED_ROWS; n++) begin
         row = directed_row(n);
         send_byte(row.rx, row.typed, row.want);
      end
      // Let the directed words drain before the random part starts.
      wait_all_reports();

      while (counted_items < RANDOM_ITEMS) begin
         if (!mid_drained && counted_items >= RANDOM_ITEMS / 2) begin
            wait_all_reports();
            mid_drained = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 40)      send_frame(KIND_U, $urandom_range(0, 4) != 0);
         else if (pick < 75) send_frame(KIND_R, $urandom_range(0, 4) != 0);
         else if (pick < 90) send_status();
         else                send_noise();
      end

      req_tvalid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d link bytes; checked %0d result words: %0d status, %0d U, %0d R.",
               bytes_sent, words_checked, status_words, u_words, r_words);
      $display("Words with a failed checksum: %0d; mismatches: %0d.", bad_sums, errors);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      #(LIMIT_CYCLES * PERIOD_NS);
      $display("Timeout with %0d words still expected.", awaited_reports.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/rsfp_pkg.sv
rtl/core/rsfp_front.sv
rtl/core/rsfp_queue.sv
rtl/core/rsfp_back.sv
rtl/core/radio_serial_frame_parser.sv
rtl/core/rsfp_checker.sv
dv/radio_serial_frame_parser_test.sv
